### design/i2a_pkg.sv
`default_nettype none
package i2a_pkg;

  localparam int VALUE_W        = 64;
  localparam int VALUE_BITS_DEF = 64;
  localparam int ACTION_W       = 2;
  localparam int CHAR_W         = 7;

  localparam logic [ACTION_W-1:0] ACT_UDEC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SDEC = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_HEX  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_BYTE = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

  // load request into the character emitter
  typedef struct packed {
    logic load;
    logic neg;
    logic two_min;
  } emit_ctl_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] r;
    if (nib < 4'd10) begin
      r = CHAR_ZERO + CHAR_W'(nib);
    end else begin
      r = CHAR_A + CHAR_W'(nib - 4'd10);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/integer_to_ascii_digits_top.sv
`default_nettype none
// Channel  Handshake            Fields
// in       in_valid / in_stall   action[1:0], value[63:0]
// out      out_valid / out_stall character[6:0], last
//
// One request at a time. Decimal modes run the shift-and-add-3 unit over
// all VALUE_BITS input bits, then the emitter drops leading zeros and
// shifts out the characters. Hex modes skip the BCD unit. rst is synchronous
// and clears the busy, active and valid flags; counters and data are not reset.
// out_stall holds the output register; in_stall stays high while a request
// is converting or its characters are still being shifted out.
module integer_to_ascii_digits_top import i2a_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [ACTION_W-1:0]  action,
  input  wire logic [VALUE_W-1:0]   value,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [CHAR_W-1:0]         character,
  output logic                      last
);

  localparam int DIGITS   = (VALUE_BITS * 3) / 10 + 1;
  localparam int DIG_BITS = DIGITS * 4;

  logic                  accept;
  logic [VALUE_BITS-1:0] v;
  logic [VALUE_BITS-1:0] mag;
  logic                  is_neg;
  logic                  is_dec;
  logic                  neg_hold;
  logic                  dab_busy;
  logic                  dab_done;
  logic [DIG_BITS-1:0]   bcd;
  logic                  emit_active;
  emit_ctl_t             ctl;
  logic [DIG_BITS-1:0]   digits;

  assign v        = value[VALUE_BITS-1:0];
  assign is_neg   = (action == ACT_SDEC) && v[VALUE_BITS-1];
  assign mag      = is_neg ? (~v + VALUE_BITS'(1)) : v;
  assign is_dec   = (action == ACT_UDEC) || (action == ACT_SDEC);
  assign in_stall = dab_busy || dab_done || emit_active;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      neg_hold <= 1'b0;
    end else if (accept) begin
      neg_hold <= is_neg;
    end
  end

  always_comb begin
    ctl.load    = dab_done || (accept && !is_dec);
    ctl.neg     = dab_done && neg_hold;
    ctl.two_min = !dab_done && (action == ACT_BYTE);
    if (dab_done) begin
      digits = bcd;
    end else if (action == ACT_BYTE) begin
      digits = DIG_BITS'(v[7:0]);
    end else begin
      digits = DIG_BITS'(v);
    end
  end

  i2a_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_dabble (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && is_dec),
    .bin_in (mag),
    .busy   (dab_busy),
    .done   (dab_done),
    .bcd    (bcd)
  );

  i2a_emit #(
    .DIGITS (DIGITS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .digits    (digits),
    .active    (emit_active),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

endmodule
`default_nettype wire

### design/i2a_dabble.sv
`default_nettype none
// Bit-serial binary to BCD (shift and add-3), one input bit per cycle.
module i2a_dabble import i2a_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int DIGITS     = (VALUE_BITS * 3) / 10 + 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [VALUE_BITS-1:0]   bin_in,
  output logic                         busy,
  output logic                         done,
  output logic [DIGITS*4-1:0]          bcd
);

  localparam int DIG_BITS = DIGITS * 4;
  localparam int CNT_W    = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] bin;
  logic [CNT_W-1:0]      cnt;
  logic [DIG_BITS-1:0]   adj;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        bin  <= bin_in;
        bcd  <= '0;
        cnt  <= CNT_W'(VALUE_BITS);
      end else if (busy) begin
        bcd <= {adj[DIG_BITS-2:0], bin[VALUE_BITS-1]};
        bin <= {bin[VALUE_BITS-2:0], 1'b0};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

### design/i2a_emit.sv
`default_nettype none
// Shifts digits out MSB first, drops leading zeros, owns the output register.
module i2a_emit import i2a_pkg::*; #(
  parameter int DIGITS = (VALUE_BITS_DEF * 3) / 10 + 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire emit_ctl_t             ctl,
  input  wire logic [DIGITS*4-1:0]   digits,
  output logic                       active,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [CHAR_W-1:0]          character,
  output logic                       last
);

  localparam int DIG_BITS = DIGITS * 4;
  localparam int CNT_W    = $clog2(DIGITS + 1);

  logic [DIG_BITS-1:0] dig;
  logic [CNT_W-1:0]    cnt;
  logic                neg;
  logic                two_min;
  logic                started;
  logic                can_emit;
  logic                skip;
  logic                emit_now;
  logic [3:0]          top_dig;

  assign top_dig  = dig[DIG_BITS-1 -: 4];
  assign can_emit = !out_valid || !out_stall;
  assign skip     = active && !started && (top_dig == 4'd0) &&
                    (cnt > (two_min ? CNT_W'(2) : CNT_W'(1)));
  assign emit_now = !ctl.load && !skip && active && can_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      neg       <= 1'b0;
      started   <= 1'b0;
    end else begin
      if (can_emit) begin
        out_valid <= emit_now;
      end
      if (ctl.load) begin
        active  <= 1'b1;
        dig     <= digits;
        cnt     <= CNT_W'(DIGITS);
        neg     <= ctl.neg;
        two_min <= ctl.two_min;
        started <= 1'b0;
      end else if (skip) begin
        dig <= {dig[DIG_BITS-5:0], 4'd0};
        cnt <= cnt - CNT_W'(1);
      end else if (active && can_emit) begin
        if (neg) begin
          character <= CHAR_MINUS;
          last      <= 1'b0;
          neg       <= 1'b0;
        end else begin
          character <= hex_char(top_dig);
          last      <= (cnt == CNT_W'(1));
          dig       <= {dig[DIG_BITS-5:0], 4'd0};
          cnt       <= cnt - CNT_W'(1);
          started   <= 1'b1;
          if (cnt == CNT_W'(1)) begin
            active <= 1'b0;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire
